>>> src/wrs_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes for the weighted random select block.
package wrs_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int FRAC_W   = 16;
    localparam int SUM_W    = WEIGHT_W + CNT_W;
    localparam int PCT_W    = 7;
    localparam int DIV_W    = SUM_W + PCT_W - 1;
    localparam int STEP_W   = $clog2(PCT_W);
    localparam int PERCENT  = 100;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;

    localparam logic [1:0] ST_DRAW_OK = 2'd0;
    localparam logic [1:0] ST_ACCEPT  = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM_RD,
        S_SUM_ACC,
        S_DIV_RD,
        S_DIV_MUL,
        S_DIV_STEP,
        S_DIV_WR,
        S_SCALE,
        S_SEL_RD,
        S_SEL_ACC,
        S_FETCH,
        S_DONE
    } wrs_state_t;

endpackage

>>> src/wrs_ram.sv
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
module wrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/weighted_random_select.sv
`timescale 1ns / 1ps
// Weighted random select: a table of up to TABLE_ENTRIES (value, weight) entries.
// Clear and push transactions complete without leaving the idle state. A draw
// walks the held entries three times through a sequencer: once to sum the
// weights, once to rescale each weight to a percentage with a shared
// restoring divider, and once to find the selected entry. The rescaled
// weights stay in the table. The input is not ready while a draw is in
// progress.
module weighted_random_select (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    operation,
    input  logic signed [31:0]            entry_value,
    input  logic [15:0]                   entry_weight,
    input  logic [15:0]                   random_fraction,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            chosen_value,
    output logic [1:0]                    status,
    output logic [wrs_pkg::CNT_W-1:0]     entry_count
);

    import wrs_pkg::*;

    wrs_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    target_reg, target_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    dvs_reg, dvs_next;
    logic [PCT_W-1:0]    quot_reg, quot_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PCT_W-1:0]    total_reg, total_next;
    logic [PCT_W-1:0]    run_reg, run_next;
    logic [PCT_W-1:0]    pick_reg, pick_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  value_out_reg, value_out_next;
    logic [1:0]          status_reg, status_next;
    logic [CNT_W-1:0]    count_out_reg, count_out_next;

    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic [WEIGHT_W-1:0] w_wdata;
    logic [WEIGHT_W-1:0] w_rdata;
    logic                v_we;
    logic [VALUE_W-1:0]  v_rdata;

    logic                accept;
    logic                last_entry;
    logic                table_full;
    logic                rem_ge;
    logic [DIV_W-1:0]    numerator;
    logic [PCT_W-1:0]    run_sum;
    logic [PCT_W-1:0]    total_plus;
    logic [PCT_W+FRAC_W-1:0] scaled;

    wrs_ram #(.WIDTH(WEIGHT_W), .DEPTH(TABLE_ENTRIES)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (idx_reg),
        .rdata (w_rdata)
    );

    wrs_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_ENTRIES)) u_value_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (entry_value),
        .raddr (target_reg),
        .rdata (v_rdata)
    );

    assign in_ready     = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign chosen_value = value_out_reg;
    assign status       = status_reg;
    assign entry_count  = count_out_reg;

    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign table_full = (count_reg >= CNT_W'(TABLE_ENTRIES));
    assign rem_ge     = (rem_reg >= dvs_reg);
    assign numerator  = (DIV_W'(w_rdata) << 6) + (DIV_W'(w_rdata) << 5)
                      + (DIV_W'(w_rdata) << 2);
    assign run_sum    = run_reg + w_rdata[PCT_W-1:0];
    assign total_plus = total_reg + PCT_W'(1);
    assign scaled     = (PCT_W+FRAC_W)'(total_plus) * (PCT_W+FRAC_W)'(frac_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        target_reg    <= target_next;
        sum_reg       <= sum_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        quot_reg      <= quot_next;
        step_reg      <= step_next;
        total_reg     <= total_next;
        run_reg       <= run_next;
        pick_reg      <= pick_next;
        frac_reg      <= frac_next;
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
        count_out_reg <= count_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        target_next    = target_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        total_next     = total_reg;
        run_next       = run_reg;
        pick_next      = pick_reg;
        frac_next      = frac_reg;
        value_out_next = value_out_reg;
        status_next    = status_reg;
        count_out_next = count_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        w_we           = 1'b0;
        w_waddr        = count_reg[IDX_W-1:0];
        w_wdata        = entry_weight;
        v_we           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_CLEAR:
                        begin
                            count_next     = '0;
                            out_valid_next = 1'b1;
                            value_out_next = '0;
                            status_next    = ST_ACCEPT;
                            count_out_next = '0;
                        end
                        OP_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            value_out_next = '0;
                            status_next    = ST_ACCEPT;
                            count_out_next = count_reg;
                            if (entry_weight != '0)
                            begin
                                if (table_full)
                                begin
                                    status_next = ST_FULL;
                                end
                                else
                                begin
                                    w_we           = 1'b1;
                                    v_we           = 1'b1;
                                    count_next     = count_reg + CNT_W'(1);
                                    count_out_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                value_out_next = '0;
                                status_next    = ST_EMPTY;
                                count_out_next = count_reg;
                            end
                            else
                            begin
                                frac_next  = random_fraction;
                                idx_next   = '0;
                                sum_next   = '0;
                                state_next = S_SUM_RD;
                            end
                        end
                    endcase
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                sum_next = sum_reg + SUM_W'(w_rdata);
                if (last_entry)
                begin
                    idx_next   = '0;
                    total_next = '0;
                    if ((sum_reg + SUM_W'(w_rdata)) == '0)
                    begin
                        target_next = '0;
                        state_next  = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_DIV_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SUM_RD;
                end
            end
            S_DIV_RD:
            begin
                state_next = S_DIV_MUL;
            end
            S_DIV_MUL:
            begin
                rem_next   = numerator;
                dvs_next   = DIV_W'(sum_reg) << (PCT_W - 1);
                quot_next  = '0;
                step_next  = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                if (rem_ge)
                begin
                    rem_next = rem_reg - dvs_reg;
                end
                quot_next = {quot_reg[PCT_W-2:0], rem_ge};
                dvs_next  = dvs_reg >> 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(PCT_W - 1))
                begin
                    state_next = S_DIV_WR;
                end
            end
            S_DIV_WR:
            begin
                w_we       = 1'b1;
                w_waddr    = idx_reg;
                w_wdata    = WEIGHT_W'(quot_reg);
                total_next = total_reg + quot_reg;
                if (last_entry)
                begin
                    idx_next   = '0;
                    state_next = S_SCALE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_DIV_RD;
                end
            end
            S_SCALE:
            begin
                pick_next  = scaled[PCT_W+FRAC_W-1:FRAC_W];
                run_next   = '0;
                state_next = S_SEL_RD;
            end
            S_SEL_RD:
            begin
                state_next = S_SEL_ACC;
            end
            S_SEL_ACC:
            begin
                run_next = run_sum;
                if (pick_reg <= run_sum)
                begin
                    target_next = idx_reg;
                    state_next  = S_FETCH;
                end
                else if (last_entry)
                begin
                    out_valid_next = 1'b1;
                    value_out_next = '0;
                    status_next    = ST_DRAW_OK;
                    count_out_next = count_reg;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SEL_RD;
                end
            end
            S_FETCH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                value_out_next = v_rdata;
                status_next    = ST_DRAW_OK;
                count_out_next = count_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("Entry count exceeds the table size.");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV_WR |-> quot_reg <= PCT_W'(PERCENT))
        else $error("Rescaled weight exceeds one hundred.");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_EMPTY |-> count_out_reg == '0)
        else $error("Empty draw reported with entries held.");

    a_draw_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && operation[1] && count_reg != '0 |=> state_reg == S_SUM_RD)
        else $error("Draw transaction did not start the summing pass.");
`endif

endmodule

>>> verif/tb_weighted_random_select.sv
`timescale 1ns / 1ps
// Testbench for weighted_random_select: random table operations checked against a predictor.
module tb_weighted_random_select;

    import wrs_pkg::*;

    localparam logic [1:0] OP_DRAW     = 2'd2;
    // Operation code three decodes as a draw because every code other than clear and push does.
    localparam logic [1:0] OP_DRAW_ALT = 2'd3;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 250;
    localparam int TARGET_OPS   = 1500;

    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic [15:0]        weight;
        logic [15:0]        frac;
        int                 gap;
        bit                 drain;
    } table_op_t;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic [CNT_W-1:0]   count;
    } outcome_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               operation = OP_CLEAR;
    logic signed [31:0]       entry_value = '0;
    logic [15:0]              entry_weight = '0;
    logic [15:0]              random_fraction = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [31:0]       chosen_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;

    table_op_t          table_ops[$];
    outcome_t           pending_outcomes[$];
    logic signed [31:0] table_values[TABLE_ENTRIES];
    logic [15:0]        table_weights[TABLE_ENTRIES];
    logic [CNT_W-1:0]   table_fill;
    int                 fail_count = 0;
    int                 op_count = 0;
    int                 idle_cycles = 0;
    int                 gap_count = 0;
    int                 rx_wait = 0;
    bit                 sender_quiet = 1'b0;
    bit                 rx_quiet = 1'b0;

    weighted_random_select dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .entry_value     (entry_value),
        .entry_weight    (entry_weight),
        .random_fraction (random_fraction),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chosen_value    (chosen_value),
        .status          (status),
        .entry_count     (entry_count)
    );

    always #5 clk = ~clk;

    task automatic add_op(input logic [1:0] op, input logic signed [31:0] value,
                          input logic [15:0] weight, input logic [15:0] frac, input bit drain);
        table_op_t item;
        if ($urandom_range(0, 49) == 0)
        begin
            sender_quiet = !sender_quiet;
        end
        item.op = op;
        item.value = value;
        item.weight = weight;
        item.frac = frac;
        item.gap = sender_quiet ? 0 : $urandom_range(0, 9);
        item.drain = drain || ($urandom_range(0, 199) == 0);
        table_ops.insert(table_ops.size(), item);
        if (!(op == OP_PUSH && weight == 0))
        begin
            op_count++;
        end
    endtask

    task automatic predict_outcome(input logic [1:0] op, input logic signed [31:0] value,
                                   input logic [15:0] weight, input logic [15:0] frac);
        outcome_t    res;
        logic [31:0] sum;
        logic [31:0] total;
        logic [31:0] thresh;
        logic [31:0] running;
        bit          found;
        int          i;
        res.value = '0;
        res.status = ST_ACCEPT;
        if (op == OP_CLEAR)
        begin
            table_fill = '0;
        end
        else if (op == OP_PUSH)
        begin
            if (weight != 0)
            begin
                if (table_fill >= TABLE_ENTRIES)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    table_values[table_fill] = value;
                    table_weights[table_fill] = weight;
                    table_fill = table_fill + 1'b1;
                end
            end
        end
        else if (table_fill == 0)
        begin
            res.status = ST_EMPTY;
        end
        else
        begin
            res.status = ST_DRAW_OK;
            sum = '0;
            for (i = 0; i < table_fill; i++)
            begin
                sum += 32'(table_weights[i]);
            end
            if (sum == 0)
            begin
                res.value = table_values[0];
            end
            else
            begin
                total = '0;
                for (i = 0; i < table_fill; i++)
                begin
                    table_weights[i] = 16'((32'(PERCENT) * 32'(table_weights[i])) / sum);
                    total += 32'(table_weights[i]);
                end
                thresh = ((total + 32'd1) * 32'(frac)) >> 16;
                running = '0;
                found = 1'b0;
                for (i = 0; i < table_fill; i++)
                begin
                    if (!found)
                    begin
                        running += 32'(table_weights[i]);
                        if (thresh <= running)
                        begin
                            res.value = table_values[i];
                            found = 1'b1;
                        end
                    end
                end
            end
        end
        res.count = table_fill;
        pending_outcomes.insert(pending_outcomes.size(), res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_ops
        logic      next_valid;
        table_op_t head;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= OP_CLEAR;
            entry_value <= '0;
            entry_weight <= '0;
            random_fraction <= '0;
            gap_count = 0;
        end
        else
        begin
            next_valid = in_valid && !in_ready;
            if (!next_valid && table_ops.size() != 0)
            begin
                if (table_ops[0].drain && (in_valid || pending_outcomes.size() != 0))
                begin
                    gap_count = 0;
                end
                else if (gap_count < table_ops[0].gap)
                begin
                    gap_count++;
                end
                else
                begin
                    head = table_ops.pop_front();
                    operation <= head.op;
                    entry_value <= head.value;
                    entry_weight <= head.weight;
                    random_fraction <= head.frac;
                    next_valid = 1'b1;
                    gap_count = 0;
                end
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_results
        outcome_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            table_fill = '0;
            rx_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_outcome(operation, entry_value, entry_weight, random_fraction);
            end
            if (out_valid && out_ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("Unexpected transaction: value %0d status %0d count %0d",
                                 chosen_value, status, entry_count);
                    end
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (chosen_value !== want.value || status !== want.status ||
                        entry_count !== want.count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("Mismatch: expected value %0d status %0d count %0d,",
                                     want.value, want.status, want.count,
                                     " got value %0d status %0d count %0d",
                                     chosen_value, status, entry_count);
                        end
                    end
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    rx_quiet = !rx_quiet;
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
            end
            out_ready <= (rx_wait == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int          scenario;
        int          fill;
        int          shape;
        int          draws;
        int          len;
        int          k;
        logic [15:0] w;
        logic [15:0] frac;

        add_op(OP_CLEAR, '0, '0, '0, 1'b0);
        add_op(OP_DRAW, 32'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        add_op(OP_PUSH, 32'($urandom), 16'd0, 16'($urandom), 1'b0);
        add_op(OP_PUSH, 32'sh8000_0000, 16'd1, 16'hffff, 1'b0);
        add_op(OP_PUSH, 32'sh7fff_ffff, 16'hffff, 16'd0, 1'b0);
        add_op(OP_DRAW, '0, '0, 16'd0, 1'b0);
        add_op(OP_DRAW_ALT, '1, '1, 16'hffff, 1'b0);
        for (k = 0; k < TABLE_ENTRIES - 2; k++)
        begin
            add_op(OP_PUSH, 32'(k * 1000 - 7000), 16'($urandom_range(1, 65535)),
                   16'($urandom), 1'b0);
        end
        add_op(OP_PUSH, 32'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom), 1'b0);
        add_op(OP_PUSH, 32'($urandom), 16'd0, 16'($urandom), 1'b0);
        add_op(OP_DRAW_ALT, 32'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        add_op(OP_CLEAR, 32'($urandom), 16'($urandom), 16'($urandom), 1'b0);

        scenario = -1;
        while (op_count < TARGET_OPS)
        begin
            if (scenario == -1)
            begin
                add_op(OP_CLEAR, '0, '0, '0, 1'b1);
            end
            scenario = $urandom_range(0, 9);
            if (scenario < 7)
            begin
                add_op(OP_CLEAR, 32'($urandom), 16'($urandom), 16'($urandom), 1'b0);
                fill = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20)
                                                   : $urandom_range(1, 8);
                shape = $urandom_range(0, 2);
                for (k = 0; k < fill; k++)
                begin
                    case (shape)
                        0: w = 16'($urandom);
                        1: w = 16'($urandom_range(1, 12));
                        default: w = ($urandom_range(0, 1) == 0) ? 16'hffff
                                                                 : 16'($urandom_range(1, 3));
                    endcase
                    if ($urandom_range(0, 19) == 0)
                    begin
                        w = '0;
                    end
                    add_op(OP_PUSH, 32'($urandom), w, 16'($urandom), 1'b0);
                end
                draws = $urandom_range(1, 6);
                for (k = 0; k < draws; k++)
                begin
                    case ($urandom_range(0, 5))
                        0: frac = 16'd0;
                        1: frac = 16'hffff;
                        default: frac = 16'($urandom);
                    endcase
                    add_op(($urandom_range(0, 3) == 0) ? OP_DRAW_ALT : OP_DRAW,
                           32'($urandom), 16'($urandom), frac, 1'b0);
                    if ($urandom_range(0, 5) == 0)
                    begin
                        add_op(OP_PUSH, 32'($urandom), 16'($urandom_range(1, 65535)),
                               16'($urandom), 1'b0);
                    end
                end
            end
            else
            begin
                len = $urandom_range(3, 12);
                for (k = 0; k < len; k++)
                begin
                    add_op(2'($urandom_range(0, 3)), 32'($urandom),
                           ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                           16'($urandom), 1'b0);
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (table_ops.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/wrs_pkg.sv
src/wrs_ram.sv
src/weighted_random_select.sv
verif/tb_weighted_random_select.sv
